// ===== design/stereo_pan_mix_clip_peak_top_defines.svh =====
// assertion macros used by the top-level design file
`ifndef STEREO_PAN_MIX_CLIP_PEAK_TOP_DEFINES_SVH
`define STEREO_PAN_MIX_CLIP_PEAK_TOP_DEFINES_SVH

// condition holds in the same cycle
`define SPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spm_pkg.sv =====
package spm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SUM_BITS    = 40;
    localparam int GAIN_W      = 16;
    localparam int PAN_W       = 17;
    localparam int GAIN_FRAC   = 14;

    // serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MC_W      = SAMPLE_BITS + 1;
    localparam int MR_W      = GAIN_W;
    localparam int PROD_W    = MC_W + MR_W;
    localparam int CONTRIB_W = PROD_W - GAIN_FRAC;

    // divider
    localparam int DIVD_W = 2 * GAIN_W;
    localparam int DEN_W  = PAN_W;

    // step counter counts 0 (load) to GAIN_W
    localparam int CNT_W = $clog2(GAIN_W + 1);

    localparam logic [PAN_W-1:0]  PAN_ONE   = PAN_W'(1 << GAIN_W);
    localparam logic [PAN_W-1:0]  PAN_HALF  = PAN_W'(1 << (GAIN_W - 1));
    localparam logic [GAIN_W-1:0] GAIN_MAX  = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0] MG_RESET  = GAIN_W'(1 << GAIN_FRAC);
    localparam int                ROUND_HALF = 1 << (GAIN_FRAC - 1);

    // stream widths
    localparam int S_TDATA_W = ((SAMPLE_BITS + GAIN_W + PAN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int TUSER_USE_MASTER = 0;
    localparam int TUSER_BUF_START  = 1;

    typedef struct packed {
        logic load;
        logic step;
    } spm_ctl_t;

    typedef struct packed {
        logic peak_clr;
        logic round_en;
        logic acc_en;
        logic close_en;
    } spm_side_ctl_t;

endpackage

// ===== design/spm_mul.sv =====
module spm_mul (
    input  logic                        aclk,
    input  spm_pkg::spm_ctl_t           ctl,
    input  logic [spm_pkg::MC_W-1:0]    mcand,
    input  logic [spm_pkg::MR_W-1:0]    mplier,
    output logic [spm_pkg::PROD_W-1:0]  prod
);
    import spm_pkg::*;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MC_W-1:0]   mcand_reg, mcand_next;
    logic [MC_W:0]     hi_sum;

    // lsb-first shift-add, one multiplier bit per step
    always_comb begin
        hi_sum = {prod_reg[PROD_W-1], prod_reg[PROD_W-1:MR_W]};
        if (prod_reg[0]) begin
            hi_sum = hi_sum + {mcand_reg[MC_W-1], mcand_reg};
        end
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        if (ctl.load) begin
            prod_next  = {{MC_W{1'b0}}, mplier};
            mcand_next = mcand;
        end else if (ctl.step) begin
            prod_next = {hi_sum, prod_reg[MR_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/spm_div.sv =====
module spm_div (
    input  logic                        aclk,
    input  spm_pkg::spm_ctl_t           ctl,
    input  logic [spm_pkg::DIVD_W-1:0]  dividend,
    input  logic [spm_pkg::DEN_W-1:0]   divisor,
    output logic [spm_pkg::GAIN_W-1:0]  quot
);
    import spm_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [GAIN_W-1:0] low_reg, low_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // restoring division, one quotient bit per step
    always_comb begin
        trial = {rem_reg, low_reg[GAIN_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
        rem_next = rem_reg;
        den_next = den_reg;
        low_next = low_reg;
        if (ctl.load) begin
            rem_next = {{(DEN_W-GAIN_W){1'b0}}, dividend[DIVD_W-1:GAIN_W]};
            low_next = dividend[GAIN_W-1:0];
            den_next = divisor;
        end else if (ctl.step) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next = {low_reg[GAIN_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
    end

    assign quot = low_reg;

endmodule

// ===== design/spm_side.sv =====
module spm_side (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  spm_pkg::spm_side_ctl_t           ctl,
    input  logic [spm_pkg::PROD_W-1:0]       prod,
    output logic [spm_pkg::SAMPLE_BITS-1:0]  clip_out,
    output logic [spm_pkg::SAMPLE_BITS-1:0]  peak_out
);
    import spm_pkg::*;

    localparam logic [SUM_BITS-1:0]    SUM_MAX  = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0]    SUM_MIN  = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] CLIP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] CLIP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [CONTRIB_W-1:0]   contrib_reg;
    logic [PROD_W-1:0]      rnd;
    logic [SUM_BITS:0]      acc;
    logic [SUM_BITS-1:0]    acc_sat;
    logic [SUM_BITS-SAMPLE_BITS:0] hi_bits;
    logic [SAMPLE_BITS-1:0] clip;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] peak_new;

    always_comb begin
        // round half up, then drop the gain fraction
        rnd = prod + PROD_W'(ROUND_HALF);

        acc = {sum_reg[SUM_BITS-1], sum_reg}
            + {{(SUM_BITS+1-CONTRIB_W){contrib_reg[CONTRIB_W-1]}}, contrib_reg};
        if (acc[SUM_BITS] != acc[SUM_BITS-1]) begin
            acc_sat = acc[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc[SUM_BITS-1:0];
        end

        // clip to sample range
        hi_bits = sum_reg[SUM_BITS-1:SAMPLE_BITS-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            clip = sum_reg[SAMPLE_BITS-1:0];
        end else begin
            clip = sum_reg[SUM_BITS-1] ? CLIP_MIN : CLIP_MAX;
        end
        mag      = clip[SAMPLE_BITS-1] ? (~clip + 1'b1) : clip;
        peak_new = (mag > peak_reg) ? mag : peak_reg;

        sum_next  = sum_reg;
        peak_next = peak_reg;
        priority if (ctl.close_en) begin
            sum_next  = '0;
            peak_next = peak_new;
        end else if (ctl.acc_en) begin
            sum_next = acc_sat;
        end else if (ctl.peak_clr) begin
            peak_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            peak_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.round_en) begin
            contrib_reg <= rnd[PROD_W-1:GAIN_FRAC];
        end
    end

    assign clip_out = clip;
    assign peak_out = peak_new;

endmodule

// ===== design/stereo_pan_mix_clip_peak_top.sv =====
// channel  | direction | handshake             | payload
// s_       | in        | s_tvalid / s_tready   | s_tdata, s_tuser, s_tlast (one source item)
// m_       | out       | m_tvalid / m_tready   | m_tdata (clipped mix and peaks)
// cfg_     | in        | cfg_valid / cfg_ready | cfg_data (master gain)
//
// one item at a time; an item runs the master gain product and rounding (when used), the pan
// law product and division (skipped for pan past full right), the sample products, rounding,
// accumulation and, on a frame's last item, the output step; the serial units take 16 steps
// a frame result waits in the output register while the next item is taken in;
// only a frame end that finds that register still full holds the block
// aresetn is synchronous, active low: sums and peaks zero, master gain unity
module stereo_pan_mix_clip_peak_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample, source_gain, source_pan
    input  logic [spm_pkg::S_TDATA_W-1:0]     s_tdata,
    // use_master, buffer_start
    input  logic [spm_pkg::S_TUSER_W-1:0]     s_tuser,
    // frame_last
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_out, right_out, peak_left_level, peak_right_level
    output logic [spm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spm_pkg::GAIN_W-1:0]        cfg_data
);
    import spm_pkg::*;
    `include "stereo_pan_mix_clip_peak_top_defines.svh"

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a source item
    localparam logic [3:0] ST_MG   = 4'd1;  // gain times master gain
    localparam logic [3:0] ST_MGF  = 4'd2;  // round and saturate the gain
    localparam logic [3:0] ST_PM   = 4'd3;  // gain times pan numerator
    localparam logic [3:0] ST_DV   = 4'd4;  // divide by pan denominator
    localparam logic [3:0] ST_SM   = 4'd5;  // sample times both side gains
    localparam logic [3:0] ST_RND  = 4'd6;  // round the contributions
    localparam logic [3:0] ST_ACC  = 4'd7;  // accumulate into the frame sums
    localparam logic [3:0] ST_OUT  = 4'd8;  // clip, peak update, result out

    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(GAIN_W);

    logic [3:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic [PAN_W-1:0]       pan_reg;
    logic                   last_reg;
    logic [GAIN_W-1:0]      mg_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    // input fields
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [GAIN_W-1:0]      gain_in;
    logic [PAN_W-1:0]       pan_in;
    logic                   accept;
    logic                   out_fire;
    logic                   phase_done;

    // pan law
    logic                   pan_over;
    logic                   pan_low;
    logic [PAN_W-1:0]       pan_comp;
    logic [GAIN_W-1:0]      pan_num;
    logic [DEN_W-1:0]       pan_den;
    logic [GAIN_W-1:0]      gain_l;
    logic [GAIN_W-1:0]      gain_r;
    logic [DIVD_W:0]        mg_rnd;
    logic [GAIN_W-1:0]      mg_gain;

    // shared units
    spm_ctl_t               mul_a_ctl, mul_b_ctl, div_ctl;
    spm_side_ctl_t          side_ctl;
    logic [MC_W-1:0]        mcand_a, mcand_b;
    logic [MR_W-1:0]        mplier_a, mplier_b;
    logic [PROD_W-1:0]      prod_a, prod_b;
    logic [GAIN_W-1:0]      quot;
    logic [SAMPLE_BITS-1:0] clip_l, clip_r, peak_l, peak_r;

    assign sample_in = s_tdata[SAMPLE_BITS-1:0];
    assign gain_in   = s_tdata[SAMPLE_BITS +: GAIN_W];
    assign pan_in    = s_tdata[SAMPLE_BITS+GAIN_W +: PAN_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_fire  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign phase_done = (cnt_reg == CNT_DONE);

    always_comb begin
        pan_over = pan_reg > PAN_ONE;
        pan_low  = pan_reg < PAN_HALF;
        pan_comp = PAN_ONE - pan_reg;
        // below one half: g*p/(1-p); otherwise g*(1-p)/p
        pan_num  = pan_low ? pan_reg[GAIN_W-1:0] : pan_comp[GAIN_W-1:0];
        pan_den  = pan_low ? pan_comp : pan_reg;
        if (pan_over) begin
            gain_l = '0;
            gain_r = '0;
        end else if (pan_low) begin
            gain_l = gain_reg;
            gain_r = quot;
        end else begin
            gain_l = quot;
            gain_r = gain_reg;
        end

        // master scaling, rounded half up and saturated
        mg_rnd  = {1'b0, prod_a[DIVD_W-1:0]} + (DIVD_W+1)'(ROUND_HALF);
        mg_gain = (|mg_rnd[DIVD_W:GAIN_FRAC+GAIN_W]) ? GAIN_MAX
                                                     : mg_rnd[GAIN_FRAC +: GAIN_W];
    end

    // operand steering into the multiplier lanes
    always_comb begin
        unique case (state_reg)
            ST_MG: begin
                mcand_a  = MC_W'(gain_reg);
                mplier_a = mg_reg;
            end
            ST_PM: begin
                mcand_a  = MC_W'(gain_reg);
                mplier_a = pan_num;
            end
            default: begin
                mcand_a  = {sample_reg[SAMPLE_BITS-1], sample_reg};
                mplier_a = gain_l;
            end
        endcase
        mcand_b  = {sample_reg[SAMPLE_BITS-1], sample_reg};
        mplier_b = gain_r;

        mul_a_ctl.load = ((state_reg == ST_MG) || (state_reg == ST_PM)
                          || (state_reg == ST_SM)) && (cnt_reg == '0);
        mul_a_ctl.step = ((state_reg == ST_MG) || (state_reg == ST_PM)
                          || (state_reg == ST_SM)) && (cnt_reg != '0);
        mul_b_ctl.load = (state_reg == ST_SM) && (cnt_reg == '0);
        mul_b_ctl.step = (state_reg == ST_SM) && (cnt_reg != '0);
        div_ctl.load   = (state_reg == ST_DV) && (cnt_reg == '0);
        div_ctl.step   = (state_reg == ST_DV) && (cnt_reg != '0);

        // peaks restart on buffer start, before this item's frame end
        side_ctl.peak_clr = accept && s_tuser[TUSER_BUF_START];
        side_ctl.round_en = (state_reg == ST_RND);
        side_ctl.acc_en   = (state_reg == ST_ACC);
        side_ctl.close_en = out_fire;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        gain_next  = gain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gain_next = gain_in;
                    if (s_tuser[TUSER_USE_MASTER]) begin
                        state_next = ST_MG;
                    end else if (pan_in > PAN_ONE) begin
                        state_next = ST_SM;
                    end else begin
                        state_next = ST_PM;
                    end
                end
            end
            ST_MG, ST_PM, ST_DV, ST_SM: begin
                if (phase_done) begin
                    unique case (state_reg)
                        ST_MG:   state_next = ST_MGF;
                        ST_PM:   state_next = ST_DV;
                        ST_DV:   state_next = ST_SM;
                        default: state_next = ST_RND;
                    endcase
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MGF: begin
                gain_next  = mg_gain;
                state_next = pan_over ? ST_SM : ST_PM;
            end
            ST_RND: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: a new result wins over the transfer of the old one
    always_comb begin
        priority if (out_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            mg_reg       <= MG_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                mg_reg <= cfg_data;
            end
        end
    end

    // item payload; sample, pan and frame flag are held for the whole item
    always_ff @(posedge aclk) begin
        gain_reg <= gain_next;
        if (accept) begin
            sample_reg <= sample_in;
            pan_reg    <= pan_in;
            last_reg   <= s_tlast;
        end
        if (out_fire) begin
            m_tdata_reg <= M_TDATA_W'({peak_r, peak_l, clip_r, clip_l});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // lane a: master gain, pan numerator and left product; lane b: right product
    spm_mul u_mul_a (
        .aclk   (aclk),
        .ctl    (mul_a_ctl),
        .mcand  (mcand_a),
        .mplier (mplier_a),
        .prod   (prod_a)
    );

    spm_mul u_mul_b (
        .aclk   (aclk),
        .ctl    (mul_b_ctl),
        .mcand  (mcand_b),
        .mplier (mplier_b),
        .prod   (prod_b)
    );

    spm_div u_div (
        .aclk     (aclk),
        .ctl      (div_ctl),
        .dividend (prod_a[DIVD_W-1:0]),
        .divisor  (pan_den),
        .quot     (quot)
    );

    spm_side u_side_l (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (side_ctl),
        .prod     (prod_a),
        .clip_out (clip_l),
        .peak_out (peak_l)
    );

    spm_side u_side_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (side_ctl),
        .prod     (prod_b),
        .clip_out (clip_r),
        .peak_out (peak_r)
    );

    // an accepted item always leaves idle
    `SPM_ASSERT_NEXT(a_accept_starts, aclk, aresetn, accept, state_reg != ST_IDLE,
        "item accepted but sequencer stayed idle")
    // rounding only follows the last multiplier step
    `SPM_ASSERT_NOW(a_rnd_after_sm, aclk, aresetn, state_reg == ST_RND,
        $past(state_reg) == ST_SM, "rounding entered without sample products")
    // a result is only produced for a frame's last item
    `SPM_ASSERT_NOW(a_out_on_last, aclk, aresetn, state_reg == ST_OUT, last_reg,
        "frame result for an item that does not end the frame")
    // a result that fires shows as valid next cycle
    `SPM_ASSERT_NEXT(a_fire_valid, aclk, aresetn, out_fire, m_tvalid,
        "frame result lost on the output register")
    // step counter never runs past the last step
    `SPM_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_DONE,
        "serial step counter out of range")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import spm_pkg::*;

    localparam int SB             = SAMPLE_BITS;
    localparam int WATCHDOG_LIMIT = 20000;  // far above one item plus both gaps and the long hold
    localparam int DRAIN_CYCLES   = 100;    // longer than the longest item
    localparam int HOLD_CYCLES    = 1500;   // long receiver hold-off, fills the output register
    localparam int PHASE_ITEMS    = 290;    // six random phases, about 1750 items in all
    localparam int MAX_REPORTS    = 40;

    typedef struct {
        logic signed [SB-1:0] sample;
        logic [GAIN_W-1:0]    gain;
        logic [PAN_W-1:0]     pan;
        bit                   use_master;
        bit                   frame_last;
        bit                   buffer_start;
    } src_item_t;

    typedef struct {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic [SB-1:0] peak_l;
        logic [SB-1:0] peak_r;
    } mix_frame_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [GAIN_W-1:0]     cfg_data;

    stereo_pan_mix_clip_peak_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // source items waiting for the driver, mixed frames waiting for the monitor
    src_item_t  pending_items[$];
    mix_frame_t mix_frames_due[$];

    // mixer state as the testbench sees it
    logic [GAIN_W-1:0] master_copy;
    longint            acc_left;
    longint            acc_right;
    longint            peak_left_copy;
    longint            peak_right_copy;

    int  errors;
    int  items_sent;
    int  frames_seen;
    int  cfg_writes;
    int  idle_cycles;
    bit  burst_mode;     // no idling on either side while set
    bit  hold_request;   // asks the monitor for one long hold-off
    bit  hold_done;
    int  hold_left;
    int  send_wait;
    int  recv_wait;
    src_item_t cur_item;

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic longint clamp_bits(longint x, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 6);
    endfunction

    // append to the tail of the driver queue
    function automatic void add_source(src_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // append to the tail of the expected frame queue
    function automatic void add_frame_due(mix_frame_t f);
        mix_frames_due.insert(mix_frames_due.size(), f);
    endfunction

    // one source item through the pan law and the frame accumulators
    function automatic void mix_source(src_item_t it);
        longint s;
        longint g;
        longint p;
        longint gl;
        longint gr;
        longint l;
        longint r;
        longint ml;
        longint mr;
        mix_frame_t f;
        s = it.sample;
        g = it.gain;
        p = it.pan;
        if (it.use_master) begin
            g = (g * longint'(master_copy) + ROUND_HALF) >>> GAIN_FRAC;
            if (g > longint'(GAIN_MAX)) g = longint'(GAIN_MAX);
        end
        if (p > longint'(PAN_ONE)) begin
            // pan past full right silences the source
            gl = 0;
            gr = 0;
        end else if (p < longint'(PAN_HALF)) begin
            gl = g;
            gr = (g * p) / (longint'(PAN_ONE) - p);
        end else begin
            gl = (g * (longint'(PAN_ONE) - p)) / p;
            gr = g;
        end
        // arithmetic shift after adding a half rounds half up
        acc_left  = clamp_bits(acc_left + ((s * gl + ROUND_HALF) >>> GAIN_FRAC), SUM_BITS);
        acc_right = clamp_bits(acc_right + ((s * gr + ROUND_HALF) >>> GAIN_FRAC), SUM_BITS);
        if (it.buffer_start) begin
            peak_left_copy  = 0;
            peak_right_copy = 0;
        end
        if (it.frame_last) begin
            l  = clamp_bits(acc_left, SB);
            r  = clamp_bits(acc_right, SB);
            ml = (l < 0) ? -l : l;
            mr = (r < 0) ? -r : r;
            if (ml > peak_left_copy) peak_left_copy = ml;
            if (mr > peak_right_copy) peak_right_copy = mr;
            f.left   = SB'(l);
            f.right  = SB'(r);
            f.peak_l = SB'(peak_left_copy);
            f.peak_r = SB'(peak_right_copy);
            add_frame_due(f);
            acc_left  = 0;
            acc_right = 0;
        end
    endfunction

    function automatic src_item_t make_item(longint sample, longint gain, longint pan,
                                            bit um, bit fl, bit bs);
        src_item_t it;
        it.sample       = SB'(sample);
        it.gain         = GAIN_W'(gain);
        it.pan          = PAN_W'(pan);
        it.use_master   = um;
        it.frame_last   = fl;
        it.buffer_start = bs;
        return it;
    endfunction

    function automatic src_item_t rand_item(bit last, bit first);
        src_item_t it;
        int unsigned pick;
        longint edge_pans[8];
        edge_pans = '{0, 1, 32767, 32768, 32769, 65535, 65536, 65537};
        it.sample = SB'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) it.sample = {1'b0, {(SB-1){1'b1}}};
        else if (pick == 1) it.sample = {1'b1, {(SB-1){1'b0}}};
        else if (pick == 2) it.sample = SB'($urandom_range(0, 64)) - SB'(32);
        it.gain = GAIN_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) it.gain = GAIN_MAX;
        else if (pick == 1) it.gain = GAIN_W'($urandom_range(0, 40));
        else if (pick == 2) it.gain = MG_RESET;
        pick = $urandom_range(0, 15);
        if (pick < 2) it.pan = PAN_W'(edge_pans[$urandom_range(0, 7)]);
        else if (pick == 2) it.pan = PAN_W'($urandom_range(65537, 131071));
        else it.pan = PAN_W'($urandom_range(0, 65536));
        it.use_master = $urandom_range(0, 1);
        it.frame_last = last;
        // restart the peaks now and then at a frame's first item, more rarely mid-frame
        it.buffer_start = first ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 31) == 0);
        return it;
    endfunction

    // whole frames of one to six sources, now and then a long one
    task automatic queue_frames(int count);
        int n;
        int len;
        n = 0;
        @(negedge aclk);
        while (n < count) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                add_source(rand_item(i == len - 1, i == 0));
            n += len;
        end
    endtask

    // everything offered is taken, every frame is back, the last item has left the pipe
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || mix_frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_master(logic [GAIN_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        master_copy = value;
        cfg_writes++;
    endtask

    task automatic check_field(string label, logic [SB-1:0] want, logic [SB-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // source side driver: one item per transfer, random gap after each, none in burst mode
    always @(posedge aclk) begin
        bit offer;
        logic [S_TUSER_W-1:0] tuser_v;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                mix_source(cur_item);
                items_sent++;
                offer     = 1'b0;
                send_wait = draw_gap();
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    // tdata: sample, source_gain, source_pan from bit 0 up
                    s_tdata <= S_TDATA_W'({cur_item.pan, cur_item.gain, cur_item.sample});
                    tuser_v = '0;
                    tuser_v[TUSER_USE_MASTER] = cur_item.use_master;
                    tuser_v[TUSER_BUF_START]  = cur_item.buffer_start;
                    s_tuser <= tuser_v;
                    s_tlast <= cur_item.frame_last;
                    offer   = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // mix side monitor: checks each frame transfer, random ready gaps outside burst mode, one long hold
    always @(posedge aclk) begin
        bit take;
        mix_frame_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                frames_seen++;
                if (mix_frames_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: frame with none expected, expected nothing, actual %h",
                                 $time, m_tdata);
                end else begin
                    want = mix_frames_due.pop_front();
                    check_field("left_out", want.left, m_tdata[0*SB +: SB]);
                    check_field("right_out", want.right, m_tdata[1*SB +: SB]);
                    check_field("peak_left_level", want.peak_l, m_tdata[2*SB +: SB]);
                    check_field("peak_right_level", want.peak_r, m_tdata[3*SB +: SB]);
                end
                recv_wait = draw_gap();
            end
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            m_tready <= take;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d items queued, %0d frames due",
                     $time, idle_cycles, pending_items.size(), mix_frames_due.size());
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [GAIN_W-1:0] settings[6];
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        master_copy     = MG_RESET;
        acc_left        = 0;
        acc_right       = 0;
        peak_left_copy  = 0;
        peak_right_copy = 0;
        errors          = 0;
        items_sent      = 0;
        frames_seen     = 0;
        cfg_writes      = 0;
        idle_cycles     = 0;
        burst_mode      = 1'b0;
        hold_request    = 1'b0;
        hold_done       = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset master gain
        @(negedge aclk);
        // full scale into the hard left and hard right, both clip
        add_source(make_item(8388607, 65535, 0, 0, 1, 1));
        add_source(make_item(-8388608, 65535, 65536, 1, 1, 0));
        // pan at one half gives equal gains, just below it takes the lower branch
        add_source(make_item(8388607, 16384, 32768, 0, 1, 0));
        add_source(make_item(4194304, 16384, 32767, 1, 1, 0));
        // pan past full right silences, even at its top code
        add_source(make_item(8388607, 65535, 65537, 0, 1, 0));
        add_source(make_item(-8388608, 65535, 131071, 1, 1, 0));
        // peak restart in the middle of a frame, sums run on
        add_source(make_item(-3000000, 20000, 10000, 0, 0, 0));
        add_source(make_item(1234567, 8000, 50000, 1, 0, 1));
        add_source(make_item(77777, 30000, 65535, 0, 1, 0));
        // peak restart on the frame's only item
        add_source(make_item(100, 16384, 40000, 0, 1, 1));
        // silent gain and rounding of tiny products
        add_source(make_item(8388607, 0, 1, 1, 1, 0));
        add_source(make_item(-1, 1, 1, 0, 1, 0));
        add_source(make_item(-1, 8192, 0, 0, 1, 0));
        add_source(make_item(1, 8192, 0, 0, 1, 0));
        // stereo pair plus an effect return in one frame
        add_source(make_item(2500000, 12000, 0, 1, 0, 0));
        add_source(make_item(-2400000, 12000, 65536, 1, 0, 0));
        add_source(make_item(600000, 16384, 32768, 0, 1, 0));
        wait_idle();

        // master gain settings, extremes among them
        settings[0] = GAIN_MAX;
        settings[1] = '0;
        settings[2] = GAIN_W'($urandom);
        settings[3] = GAIN_W'(1);
        settings[4] = GAIN_W'($urandom_range(8192, 32768));
        settings[5] = MG_RESET;
        for (int ph = 0; ph < 6; ph++) begin
            write_master(settings[ph]);
            @(negedge aclk);
            burst_mode = (ph == 1);
            if (ph == 2) hold_request <= 1'b1;
            queue_frames(PHASE_ITEMS);
            wait_idle();
        end

        $display("covered %0d source items, %0d mixed frames, %0d master gain writes",
                 items_sent, frames_seen, cfg_writes);
        $display("pan edges, silent pans, clipping, peak restarts and a long output stall included");
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
